// File: sv/calendar_to_epoch_seconds_macros.svh
// ---------------------------------------------------------------------------
// Calendar to epoch seconds: assertion macros
// Shared property macros for the checker of the conversion block.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_TO_EPOCH_SECONDS_MACROS_SVH
`define CALENDAR_TO_EPOCH_SECONDS_MACROS_SVH

// Overlapping implication, checked at every rising clock edge outside reset.
`define CTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calendar_to_epoch_seconds: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar_to_epoch_seconds: assertion failed");

`endif

// File: sv/cte_pkg.sv
// ---------------------------------------------------------------------------
// Calendar to epoch seconds: package
// Item types, pipeline stage types and constants shared by the block.
// ---------------------------------------------------------------------------
package cte_pkg;

	localparam int BASE_YEAR_DEFAULT = 1969;
	localparam int EPOCH_YEAR        = 1970;
	localparam int CAL_BASE          = 1900;
	localparam int SEC_PER_DAY       = 86400;

	localparam int YEAR_W      = 12;
	localparam int Q_W         = 5;
	localparam int DAY_W       = 19;
	localparam int HMS_W       = 20;
	localparam int EPOCH_W     = 36;
	localparam int SUM_W       = 38;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int MW_W        = 12;

	localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day_of_month;
		logic [3:0] month_index;
		logic [9:0] years_since_1900;
		logic       daylight_in_effect;
	} in_item_t;

	typedef struct packed {
		logic signed [EPOCH_W-1:0] epoch_seconds;
		logic                      field_error;
	} result_t;

	typedef struct packed {
		logic              err;
		logic [YEAR_W-1:0] y;
		logic [Q_W-1:0]    qp;
		logic [Q_W-1:0]    qy;
		logic [8:0]        dbm;
		logic              march_on;
		logic [5:0]        day;
		logic [4:0]        hr;
		logic [5:0]        min;
		logic [5:0]        sec;
		logic              dst;
	} s1_t;

	typedef struct packed {
		logic                    err;
		logic [DAY_W-1:0]        days;
		logic signed [HMS_W-1:0] hms;
	} s2_t;

	typedef struct packed {
		logic                    err;
		logic [EPOCH_W-1:0]      prod;
		logic signed [HMS_W-1:0] hms;
	} s3_t;

endpackage

// File: sv/calendar_to_epoch_seconds.sv
// ---------------------------------------------------------------------------
// Calendar to epoch seconds
// Converts a broken-down local time into signed seconds since 1970.
// ---------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low.
// The result appears on result with done high for exactly one cycle,
// after the item has passed the decode, day count, scale and sum registers.
// The pipeline has four register stages: decode, day count, scaling by
// 86400, and the final sum; one item can enter every cycle, so the
// sustained rate is one item per clock.
// The receiver cannot stall: every result is shown for one cycle only.
// The minutes_west register is written through cfg_valid, cfg_ready and
// cfg_data; write it only while no item is in flight.
// Reset clears the pipeline valid bits and the register to zero, and holds
// busy high for the first cycle after reset is released.
// A field out of range gives epoch_seconds of all ones and field_error set.
// ---------------------------------------------------------------------------
module calendar_to_epoch_seconds #(
	parameter int BASE_YEAR = cte_pkg::BASE_YEAR_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  cte_pkg::in_item_t         item,
	output logic                      done,
	output cte_pkg::result_t          result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cte_pkg::MW_W-1:0]  cfg_data
);
	import cte_pkg::*;

	logic              busy_q;
	logic signed [MW_W-1:0] minutes_west_q;
	logic              in_valid;
	logic              valid_s1;
	s1_t               data_s1;
	logic              valid_s2;
	s2_t               data_s2;

	assign busy = busy_q;
	assign cfg_ready = !busy_q;
	assign in_valid = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			minutes_west_q <= '0;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				minutes_west_q <= $signed(cfg_data);
			end
		end
	end

	cte_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	cte_count #(
		.BASE_YEAR (BASE_YEAR)
	) u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1),
		.minutes_west (minutes_west_q),
		.valid_s2     (valid_s2),
		.data_s2      (data_s2)
	);

	cte_combine #(
		.BASE_YEAR (BASE_YEAR)
	) u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.done     (done),
		.result   (result)
	);

endmodule

// File: sv/cte_decode.sv
// ---------------------------------------------------------------------------
// Calendar to epoch seconds: field decode stage
// Checks field ranges, folds hour 24 into the next day and forms the
// century quotients of the year by reciprocal multiplication.
// ---------------------------------------------------------------------------
module cte_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  cte_pkg::in_item_t item,
	output logic              valid_s1,
	output cte_pkg::s1_t      data_s1
);
	import cte_pkg::*;

	s1_t                  nxt;
	logic [YEAR_W-1:0]    y;
	logic [YEAR_W-1:0]    p;
	logic [2*YEAR_W:0]    mp;
	logic [2*YEAR_W:0]    my;

	always_comb begin
		y = YEAR_W'(item.years_since_1900) + YEAR_W'(CAL_BASE);
		p = y - YEAR_W'(1);
		mp = (2*YEAR_W+1)'(p) * (2*YEAR_W+1)'(RECIP_100);
		my = (2*YEAR_W+1)'(y) * (2*YEAR_W+1)'(RECIP_100);
		nxt.err = (item.month_index > 4'd11) || (item.day_of_month == 5'd0)
			|| (item.hour > 5'd24) || (item.minute > 6'd59) || (item.second > 6'd59);
		nxt.y = y;
		nxt.qp = mp[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
		nxt.qy = my[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
		nxt.dbm = (item.month_index <= 4'd11) ? DAYS_BEFORE_MONTH[item.month_index] : 9'd0;
		nxt.march_on = (item.month_index >= 4'd2);
		if (item.hour == 5'd24) begin
			nxt.hr = 5'd0;
			nxt.day = 6'(item.day_of_month) + 6'd1;
		end else begin
			nxt.hr = item.hour;
			nxt.day = 6'(item.day_of_month);
		end
		nxt.min = item.minute;
		nxt.sec = item.second;
		nxt.dst = item.daylight_in_effect;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

// File: sv/cte_count.sv
// ---------------------------------------------------------------------------
// Calendar to epoch seconds: day count stage
// Counts whole days from the base year, adds the leap day, month and day,
// and forms the time-of-day seconds with zone and daylight correction.
// ---------------------------------------------------------------------------
module cte_count #(
	parameter int BASE_YEAR = cte_pkg::BASE_YEAR_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  cte_pkg::s1_t                     data_s1,
	input  logic signed [cte_pkg::MW_W-1:0]  minutes_west,
	output logic                             valid_s2,
	output cte_pkg::s2_t                     data_s2
);
	import cte_pkg::*;

	localparam int LB = ((BASE_YEAR - 1) / 4) - ((BASE_YEAR - 1) / 100)
		+ ((BASE_YEAR - 1) / 400);

	s2_t               nxt;
	logic [YEAR_W-1:0] p;
	logic [YEAR_W-2:0] lb_y;
	logic [YEAR_W-1:0] rem;
	logic              leap;
	logic [DAY_W-1:0]  years;
	logic [17:0]       pos;

	always_comb begin
		p = data_s1.y - YEAR_W'(1);
		lb_y = (YEAR_W-1)'(p[YEAR_W-1:2]) + (YEAR_W-1)'(data_s1.qp[Q_W-1:2])
			- (YEAR_W-1)'(data_s1.qp);
		rem = data_s1.y - YEAR_W'(data_s1.qy) * YEAR_W'(100);
		leap = (data_s1.y[1:0] == 2'b00) && ((rem != '0) || (data_s1.qy[1:0] == 2'b00));
		if (data_s1.y > YEAR_W'(BASE_YEAR)) begin
			years = DAY_W'(data_s1.y - YEAR_W'(BASE_YEAR)) * DAY_W'(365)
				+ DAY_W'(lb_y) - DAY_W'(LB);
		end else begin
			years = '0;
		end
		nxt.err = data_s1.err;
		nxt.days = years + DAY_W'(leap && data_s1.march_on) + DAY_W'(data_s1.dbm)
			+ DAY_W'(data_s1.day) - DAY_W'(1);
		pos = 18'(data_s1.hr) * 18'd3600 + 18'(data_s1.min) * 18'd60 + 18'(data_s1.sec);
		nxt.hms = $signed({2'b00, pos}) + HMS_W'(minutes_west) * 20'sd60
			- (data_s1.dst ? 20'sd3600 : 20'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= nxt;
	end

endmodule

// File: sv/cte_combine.sv
// ---------------------------------------------------------------------------
// Calendar to epoch seconds: scale and sum stages
// Scales the day count to seconds, then adds the time of day, removes the
// distance from the base year to 1970 and drives the result register.
// ---------------------------------------------------------------------------
module cte_combine #(
	parameter int BASE_YEAR = cte_pkg::BASE_YEAR_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	input  cte_pkg::s2_t     data_s2,
	output logic             done,
	output cte_pkg::result_t result
);
	import cte_pkg::*;

	localparam int LB = ((BASE_YEAR - 1) / 4) - ((BASE_YEAR - 1) / 100)
		+ ((BASE_YEAR - 1) / 400);
	localparam int LB_EPOCH = ((EPOCH_YEAR - 1) / 4) - ((EPOCH_YEAR - 1) / 100)
		+ ((EPOCH_YEAR - 1) / 400);
	localparam int DAYS_TO_EPOCH = 365 * (EPOCH_YEAR - BASE_YEAR) + LB_EPOCH - LB;
	localparam longint OFFSET_SEC = longint'(DAYS_TO_EPOCH) * longint'(SEC_PER_DAY);

	logic               valid_s3;
	s3_t                data_s3;
	s3_t                nxt3;
	logic signed [SUM_W-1:0] sum;
	result_t            nxt4;

	always_comb begin
		nxt3.err = data_s2.err;
		nxt3.prod = EPOCH_W'(data_s2.days) * EPOCH_W'(SEC_PER_DAY);
		nxt3.hms = data_s2.hms;
	end

	always_comb begin
		sum = $signed({2'b00, data_s3.prod}) + SUM_W'(data_s3.hms) - SUM_W'(OFFSET_SEC);
		nxt4.field_error = data_s3.err;
		nxt4.epoch_seconds = data_s3.err ? '1 : sum[EPOCH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		data_s3 <= nxt3;
		result <= nxt4;
	end

endmodule

// File: sv/cte_checker.sv
// ---------------------------------------------------------------------------
// Calendar to epoch seconds: port checker
// Watches the top level's ports for latency, busy, result and error behavior.
// ---------------------------------------------------------------------------
`include "calendar_to_epoch_seconds_macros.svh"

module cte_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input cte_pkg::result_t result
);
	import cte_pkg::*;

	`CTE_ASSERT_IMPLY(a_latency, clk, arst_n, start && !busy, ##4 done)
	`CTE_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(start && !busy, 4))
	`CTE_ASSERT_IMPLY(a_error_value, clk, arst_n, done && result.field_error, &result.epoch_seconds)
	`CTE_ASSERT_NEXT(a_busy_stays_low, clk, arst_n, !busy, !busy)

endmodule

bind calendar_to_epoch_seconds cte_checker u_cte_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
